// ===== design/itm_pkg.sv =====
// Package: payload types and fixed-point constants of the inverse exponential tone map.
package itm_pkg;

    localparam int WIDE   = 24;   // working channel precision, Q0.24
    localparam int R_QW   = 21;   // quotient bits of channel / luminance ratio
    localparam int T_QW   = 39;   // quotient bits of the tone scale T16
    localparam int NL_W   = 27;   // width of -log2 and -ln results in Q.24

    localparam logic [WIDE-1:0] W_R     = 24'd3568027;
    localparam logic [WIDE-1:0] W_G     = 24'd11998394;
    localparam logic [WIDE-1:0] W_B     = 24'd1210795;
    localparam logic [WIDE-1:0] LN2_Q24 = 24'd11629080;
    localparam logic [WIDE:0]   ONE_Q24 = 25'd16777216;
    localparam logic [WIDE:0]   FLOOR_T = 25'd167772;

    localparam logic [15:0] MIDDLE_GRAY_RST = 16'd11796;
    localparam logic [15:0] AVG_LOG_LUM_RST = 16'd4096;

    localparam logic REG_MIDDLE_GRAY = 1'b0;
    localparam logic REG_AVG_LOG_LUM = 1'b1;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic        saturated;
    } pix_out_t;

endpackage

// ===== design/inverse_exp_tone_map.sv =====
// Top level: pipelined inverse exponential tone map with APB register port.
//
//  channel   dir   handshake            beat
//  -------   ---   ------------------   --------------------------------
//  pixel in  in    in_valid/in_ready    pix_in_t, three Q0.16 channels
//  pixel out out   out_valid/out_ready  pix_out_t, three Q16.16 + flag
//  config    in    APB psel/penable     two 16-bit registers at 0 and 4
//
// One beat is accepted per clock while the skid stage holds no beat;
// the accepting edge loads the first of 71 register stages:
// 3 front stages, 24 log cells (one squaring each), 3 scaling stages,
// 39 divider cells for the tone scale, one product stage and the output
// register. The channel ratio dividers (21 cells) run beside the log chain.
// No clearing pass: reset only clears the valid flags and loads the register
// defaults. A stall on the output side parks one beat in a skid stage and
// then freezes the chain.
module inverse_exp_tone_map #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  itm_pkg::pix_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output itm_pkg::pix_out_t out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int WIDE   = itm_pkg::WIDE;
    localparam int R_QW   = itm_pkg::R_QW;
    localparam int T_QW   = itm_pkg::T_QW;
    localparam int NL_W   = itm_pkg::NL_W;
    localparam int LOG_N  = WIDE;
    localparam int R_DW   = 40;
    localparam int T_DW   = 16;
    localparam int R_OUT  = 2 + R_QW;                    // stage where ratios finish
    localparam int T_OUT  = 3 + LOG_N + 3 + T_QW;        // stage where T16 finishes
    localparam int R_DLY  = T_OUT - R_OUT;
    localparam int Z_DLY  = T_OUT - 2;
    localparam int LAST   = T_OUT + 1;
    localparam int T_LO   = 20;
    localparam int T_HI   = T_QW - T_LO;

    // ---------------- register port ----------------
    logic [15:0] middle_gray_reg;
    logic [15:0] avg_log_lum_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            middle_gray_reg <= itm_pkg::MIDDLE_GRAY_RST;
            avg_log_lum_reg <= itm_pkg::AVG_LOG_LUM_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                itm_pkg::REG_MIDDLE_GRAY: middle_gray_reg <= pwdata[15:0];
                itm_pkg::REG_AVG_LOG_LUM: avg_log_lum_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            itm_pkg::REG_MIDDLE_GRAY: prdata = {16'd0, middle_gray_reg};
            itm_pkg::REG_AVG_LOG_LUM: prdata = {16'd0, avg_log_lum_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic          en;
    logic          skid_valid_reg;
    logic [LAST:1] vld_reg;

    assign in_ready = !skid_valid_reg;
    assign en       = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:1], in_valid};
        end
    end

    // ---------------- stage 1: widen and weight ----------------
    logic [WIDE-1:0]   c24_in [3];
    logic [WIDE-1:0]   s1_c_reg [3];
    logic [2*WIDE-1:0] s1_p_reg [3];

    always_comb
    begin
        c24_in[0] = WIDE'(CHANNEL_BITS'(in_data.red_in))   << (WIDE - CHANNEL_BITS);
        c24_in[1] = WIDE'(CHANNEL_BITS'(in_data.green_in)) << (WIDE - CHANNEL_BITS);
        c24_in[2] = WIDE'(CHANNEL_BITS'(in_data.blue_in))  << (WIDE - CHANNEL_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg <= c24_in;
            s1_p_reg[0] <= c24_in[0] * itm_pkg::W_R;
            s1_p_reg[1] <= c24_in[1] * itm_pkg::W_G;
            s1_p_reg[2] <= c24_in[2] * itm_pkg::W_B;
        end
    end

    // ---------------- stage 2: luminance ----------------
    logic [2*WIDE-1:0] lum_sum;
    logic [WIDE-1:0]   s2_c_reg [3];
    logic [R_DW-1:0]   s2_l40_reg;
    logic [WIDE-1:0]   s2_l24_reg;
    logic              s2_zero_reg;

    assign lum_sum = s1_p_reg[0] + s1_p_reg[1] + s1_p_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_c_reg    <= s1_c_reg;
            s2_l40_reg  <= lum_sum[2*WIDE-1:8];
            s2_l24_reg  <= lum_sum[2*WIDE-1:WIDE];
            s2_zero_reg <= (lum_sum == '0);
        end
    end

    // ---------------- stage 3: 1 - L, clamp, normalize ----------------
    logic [WIDE:0] t_raw;
    logic [WIDE:0] t_cl;
    logic [2:0]    e_nx;
    logic [WIDE:0] s3_x_reg;
    logic [2:0]    s3_e_reg;

    always_comb
    begin
        t_raw = itm_pkg::ONE_Q24 - {1'b0, s2_l24_reg};
        t_cl  = (t_raw < itm_pkg::FLOOR_T) ? itm_pkg::FLOOR_T : t_raw;
        // t stays above 2^17, so the leading one is in the top eight bits
        e_nx = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if (t_cl[WIDE-i])
            begin
                e_nx = 3'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_x_reg <= t_cl << e_nx;
            s3_e_reg <= e_nx;
        end
    end

    // ---------------- log chain ----------------
    logic [WIDE:0]   lx_w [LOG_N+1];
    logic [WIDE-1:0] lf_w [LOG_N+1];
    logic [2:0]      le_w [LOG_N+1];

    assign lx_w[0] = s3_x_reg;
    assign lf_w[0] = '0;
    assign le_w[0] = s3_e_reg;

    for (genvar k = 0; k < LOG_N; k++)
    begin : g_log
        itm_log_cell u_cell (
            .clk      (clk),
            .en       (en),
            .x_in     (lx_w[k]),
            .frac_in  (lf_w[k]),
            .e_in     (le_w[k]),
            .x_reg    (lx_w[k+1]),
            .frac_reg (lf_w[k+1]),
            .e_reg    (le_w[k+1])
        );
    end

    // ---------------- scaling: ln, times average, over gray ----------------
    logic [NL_W-1:0]      nl2;
    logic [NL_W+WIDE-1:0] s28_prod_reg;
    logic [NL_W+WIDE:0]   rnd_sum;
    logic [NL_W-1:0]      s29_n24_reg;
    logic [NL_W+15:0]     n_prod;
    logic [T_QW-1:0]      s30_d_reg;
    logic [T_DW-1:0]      s30_g_reg;

    assign nl2     = (NL_W'(le_w[LOG_N]) << WIDE) - NL_W'(lf_w[LOG_N]);
    assign rnd_sum = {1'b0, s28_prod_reg} + (NL_W+WIDE+1)'(1 << (WIDE - 1));
    assign n_prod  = s29_n24_reg * avg_log_lum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s28_prod_reg <= nl2 * itm_pkg::LN2_Q24;
            s29_n24_reg  <= rnd_sum[NL_W+WIDE-1:WIDE];
            s30_d_reg    <= n_prod[NL_W+15:4];
            // a zero gray register reads as one
            s30_g_reg    <= (middle_gray_reg == '0) ? T_DW'(1) : middle_gray_reg;
        end
    end

    // ---------------- tone scale divider ----------------
    logic [T_DW-1:0] tr_w [T_QW+1];
    logic [T_QW-1:0] tn_w [T_QW+1];
    logic [T_QW-1:0] tq_w [T_QW+1];
    logic [T_DW-1:0] td_w [T_QW+1];

    assign tr_w[0] = '0;
    assign tn_w[0] = s30_d_reg;
    assign tq_w[0] = '0;
    assign td_w[0] = s30_g_reg;

    for (genvar k = 0; k < T_QW; k++)
    begin : g_tdiv
        itm_div_cell #(.DW(T_DW), .QW(T_QW)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (tr_w[k]),
            .num_in  (tn_w[k]),
            .quo_in  (tq_w[k]),
            .div_in  (td_w[k]),
            .rem_reg (tr_w[k+1]),
            .num_reg (tn_w[k+1]),
            .quo_reg (tq_w[k+1]),
            .div_reg (td_w[k+1])
        );
    end

    // ---------------- channel ratio dividers ----------------
    logic [R_QW-1:0] r_res [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        logic [R_DW-1:0]      rr_w [R_QW+1];
        logic [R_QW-1:0]      rn_w [R_QW+1];
        logic [R_QW-1:0]      rq_w [R_QW+1];
        logic [R_DW-1:0]      rd_w [R_QW+1];
        logic [WIDE+31:0]     dvd;

        assign dvd     = {s2_c_reg[c], 32'd0};
        assign rr_w[0] = R_DW'(dvd >> R_QW);
        assign rn_w[0] = dvd[R_QW-1:0];
        assign rq_w[0] = '0;
        assign rd_w[0] = s2_l40_reg;

        for (genvar k = 0; k < R_QW; k++)
        begin : g_rdiv
            itm_div_cell #(.DW(R_DW), .QW(R_QW)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (rr_w[k]),
                .num_in  (rn_w[k]),
                .quo_in  (rq_w[k]),
                .div_in  (rd_w[k]),
                .rem_reg (rr_w[k+1]),
                .num_reg (rn_w[k+1]),
                .quo_reg (rq_w[k+1]),
                .div_reg (rd_w[k+1])
            );
        end

        assign r_res[c] = rq_w[R_QW];
    end

    // hold the ratios and the black flag until the tone scale catches up
    logic [R_QW-1:0] r_dly_reg [R_DLY][3];
    logic            z_dly_reg [Z_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_dly_reg[0] <= r_res;
            for (int i = 1; i < R_DLY; i++)
            begin
                r_dly_reg[i] <= r_dly_reg[i-1];
            end
            z_dly_reg[0] <= s2_zero_reg;
            for (int i = 1; i < Z_DLY; i++)
            begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
        end
    end

    // ---------------- product stage ----------------
    logic [R_QW+T_HI-1:0] ph_reg [3];
    logic [R_QW+T_LO-1:0] pl_reg [3];
    logic                 s_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ph_reg[c] <= r_dly_reg[R_DLY-1][c] * tq_w[T_QW][T_QW-1:T_LO];
                pl_reg[c] <= r_dly_reg[R_DLY-1][c] * tq_w[T_QW][T_LO-1:0];
            end
            s_zero_reg <= z_dly_reg[Z_DLY-1];
        end
    end

    // ---------------- final sum, saturate ----------------
    localparam int PW = R_QW + T_QW + 1;

    itm_pkg::pix_out_t res;
    logic [31:0]       ch_val [3];
    logic [2:0]        ch_over;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [PW-1:0]    full;
            logic [PW-17:0]   shr;
            full = (PW'(ph_reg[c]) << T_LO) + PW'(pl_reg[c]);
            shr  = full[PW-1:16];
            ch_over[c] = |shr[PW-17:32];
            ch_val[c]  = ch_over[c] ? 32'hFFFF_FFFF : shr[31:0];
            if (s_zero_reg)
            begin
                ch_val[c]  = 32'd0;
                ch_over[c] = 1'b0;
            end
        end
        res.red_out   = ch_val[0];
        res.green_out = ch_val[1];
        res.blue_out  = ch_val[2];
        res.saturated = |ch_over;
    end

    // ---------------- output register and skid ----------------
    itm_pkg::pix_out_t out_reg;
    itm_pkg::pix_out_t skid_reg;
    logic              out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vld_reg[LAST])
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (vld_reg[LAST])
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/itm_log_cell.sv =====
// One squaring step of the -log2 fraction extraction.
module itm_log_cell (
    input  logic                      clk,
    input  logic                      en,
    input  logic [itm_pkg::WIDE:0]    x_in,
    input  logic [itm_pkg::WIDE-1:0]  frac_in,
    input  logic [2:0]                e_in,
    output logic [itm_pkg::WIDE:0]    x_reg,
    output logic [itm_pkg::WIDE-1:0]  frac_reg,
    output logic [2:0]                e_reg
);

    logic [2*itm_pkg::WIDE+1:0] sq;
    logic [itm_pkg::WIDE+1:0]   y;
    logic [itm_pkg::WIDE:0]     x_next;
    logic [itm_pkg::WIDE-1:0]   frac_next;

    always_comb
    begin
        sq = x_in * x_in;
        y  = sq[2*itm_pkg::WIDE+1:itm_pkg::WIDE];
        // halve and emit a one bit when the square reached two
        if (y[itm_pkg::WIDE+1])
        begin
            x_next = y[itm_pkg::WIDE+1:1];
        end
        else
        begin
            x_next = y[itm_pkg::WIDE:0];
        end
        frac_next = {frac_in[itm_pkg::WIDE-2:0], y[itm_pkg::WIDE+1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            frac_reg <= frac_next;
            e_reg    <= e_in;
        end
    end

endmodule

// ===== design/itm_div_cell.sv =====
// One restoring long-division step: one quotient bit per cell.
module itm_div_cell #(
    parameter int DW = 16,
    parameter int QW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [QW-1:0] quo_in,
    input  logic [DW-1:0] div_in,
    output logic [DW-1:0] rem_reg,
    output logic [QW-1:0] num_reg,
    output logic [QW-1:0] quo_reg,
    output logic [DW-1:0] div_reg
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        trial = {rem_in, num_in[QW-1]};
        diff  = trial - {1'b0, div_in};
        ge    = (trial >= {1'b0, div_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_in[QW-2:0], 1'b0};
            quo_reg <= {quo_in[QW-2:0], ge};
            div_reg <= div_in;
        end
    end

endmodule

// ===== design/itm_checker.sv =====
// Port-level checker for the inverse exponential tone map, with its bind.
module itm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input itm_pkg::pix_out_t out_data,
    input logic              pready
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result beat changed while stalled");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.red_out == 32'hFFFF_FFFF) ||
            (out_data.green_out == 32'hFFFF_FFFF) ||
            (out_data.blue_out == 32'hFFFF_FFFF))
        else $error("saturated flag without a clamped channel");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port inserted a wait state");

endmodule

bind inverse_exp_tone_map itm_checker u_itm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);

// ===== dv/tb_inverse_exp_tone_map.sv =====
// Testbench for the inverse exponential tone map: predicted results, random pixels and stalls.
module tb_inverse_exp_tone_map;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNEL_BITS = 16;
    localparam int DUT_LATENCY  = 71;
    localparam int STALL_LIMIT  = 20000;

    // Register byte addresses: index times four.
    localparam logic [2:0] ADDR_MIDDLE_GRAY = 3'd0;
    localparam logic [2:0] ADDR_AVG_LOG_LUM = 3'd4;

    // Idle phase codes: which sides stall; set_idle_phase gives the stall rates in percent.
    typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_e;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    itm_pkg::pix_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    itm_pkg::pix_out_t out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned       mismatch_count;
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    bit                hold_off;
    bit                run_done;

    // Predictor copy of the two registers.
    logic [15:0]       gray_reg;
    logic [15:0]       avg_lum_reg;

    inverse_exp_tone_map #(.CHANNEL_BITS(CHANNEL_BITS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // -ln(t) in Q.24 via normalization and 24 squaring steps.
    function automatic logic [63:0] neg_ln_q24(input logic [63:0] t);
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] frac;
        logic [63:0] nl2;
        x = t;
        e = 0;
        frac = 0;
        while (x < 64'(itm_pkg::ONE_Q24) && e < 32)
        begin
            x = x << 1;
            e++;
        end
        for (int i = 0; i < itm_pkg::WIDE; i++)
        begin
            x = (x * x) >> itm_pkg::WIDE;
            frac = frac << 1;
            if (x >= (64'(itm_pkg::ONE_Q24) << 1))
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        nl2 = (e << itm_pkg::WIDE) - frac;
        return (nl2 * 64'(itm_pkg::LN2_Q24) + (64'(itm_pkg::ONE_Q24) >> 1)) >> itm_pkg::WIDE;
    endfunction

    // Recover linear color from one tone-mapped pixel under current registers.
    function automatic itm_pkg::pix_out_t recover_linear(input itm_pkg::pix_in_t px);
        logic [63:0] chan [3];
        logic [63:0] lum_sum;
        logic [63:0] lum40;
        logic [63:0] lum24;
        logic [63:0] t;
        logic [63:0] n24;
        logic [63:0] gray;
        logic [63:0] t16;
        logic [63:0] r16;
        logic [95:0] v;
        logic [31:0] res [3];
        itm_pkg::pix_out_t o;
        chan[0] = 64'(px.red_in)   << (itm_pkg::WIDE - CHANNEL_BITS);
        chan[1] = 64'(px.green_in) << (itm_pkg::WIDE - CHANNEL_BITS);
        chan[2] = 64'(px.blue_in)  << (itm_pkg::WIDE - CHANNEL_BITS);
        lum_sum = 64'(itm_pkg::W_R) * chan[0] + 64'(itm_pkg::W_G) * chan[1]
                + 64'(itm_pkg::W_B) * chan[2];
        o = '0;
        if (lum_sum == 0)
            return o;
        lum40 = lum_sum >> 8;
        lum24 = lum_sum >> itm_pkg::WIDE;
        t = (lum24 < 64'(itm_pkg::ONE_Q24)) ? 64'(itm_pkg::ONE_Q24) - lum24 : 64'd0;
        if (t < 64'(itm_pkg::FLOOR_T))
            t = 64'(itm_pkg::FLOOR_T);
        n24 = neg_ln_q24(t);
        gray = (gray_reg == 0) ? 64'd1 : 64'(gray_reg);
        t16 = (n24 * 64'(avg_lum_reg)) / (64'd16 * gray);
        for (int k = 0; k < 3; k++)
        begin
            r16 = (chan[k] << 32) / lum40;
            v = (96'(r16) * 96'(t16)) >> 16;
            if (v > 96'hFFFF_FFFF)
            begin
                res[k] = 32'hFFFF_FFFF;
                o.saturated = 1'b1;
            end
            else
                res[k] = v[31:0];
        end
        o.red_out = res[0];
        o.green_out = res[1];
        o.blue_out = res[2];
        return o;
    endfunction

    // Holds the predicted pixels in acceptance order and checks each result against them.
    class pixel_scoreboard;
        itm_pkg::pix_out_t pending_pix[$];

        function void note_pixel(itm_pkg::pix_out_t want);
            pending_pix.push_back(want);
        endfunction

        function int pending();
            return pending_pix.size();
        endfunction

        task check_pixel(itm_pkg::pix_out_t got);
            itm_pkg::pix_out_t want;
            if (pending_pix.size() == 0)
            begin
                report_mismatch("unexpected beat", got.red_out, 32'h0);
                return;
            end
            want = pending_pix.pop_front();
            if (got.red_out !== want.red_out)
                report_mismatch("red_out", got.red_out, want.red_out);
            if (got.green_out !== want.green_out)
                report_mismatch("green_out", got.green_out, want.green_out);
            if (got.blue_out !== want.blue_out)
                report_mismatch("blue_out", got.blue_out, want.blue_out);
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        endtask
    endclass

    pixel_scoreboard pix_sb = new();

    // Map a phase to the two stall percentages.
    task automatic set_idle_phase(input idle_phase_e ph);
        case (ph)
            PH_NONE: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            PH_SRC:  begin src_idle_pct = 60; snk_idle_pct = 0;  end
            PH_SNK:  begin src_idle_pct = 0;  snk_idle_pct = 60; end
            default: begin src_idle_pct = 26; snk_idle_pct = 26; end
        endcase
    endtask

    // APB write: setup cycle then access cycle; the register takes it on the access edge.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MIDDLE_GRAY)
            gray_reg = value[15:0];
        else if (addr == ADDR_AVG_LOG_LUM)
            avg_lum_reg = value[15:0];
        @(posedge clk);
    endtask

    // Drain everything outstanding, then let the pipe settle before touching registers.
    task automatic wait_idle();
        while (pix_sb.pending() != 0)
            @(posedge clk);
        repeat (DUT_LATENCY + 4) @(posedge clk);
    endtask

    // Hold valid and payload until accepted; valid stays high across beats unless src idles.
    task automatic send_pixel(input itm_pkg::pix_in_t px);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pix_sb.note_pixel(recover_linear(px));
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return 16'hFFFF - 16'($urandom_range(4095));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic itm_pkg::pix_in_t rand_pixel();
        itm_pkg::pix_in_t px;
        px.red_in   = rand_chan();
        px.green_in = rand_chan();
        px.blue_in  = rand_chan();
        return px;
    endfunction

    function automatic itm_pkg::pix_in_t mk_pixel(input logic [15:0] r, input logic [15:0] g,
                                                 input logic [15:0] b);
        itm_pkg::pix_in_t px;
        px.red_in = r;
        px.green_in = g;
        px.blue_in = b;
        return px;
    endfunction

    // Directed corners: black, full white, single channels, tiny and near-one luminance.
    task automatic run_directed();
        send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000));
        send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h0000));
        send_pixel(mk_pixel(16'h0000, 16'hFFFF, 16'h0000));
        send_pixel(mk_pixel(16'h0000, 16'h0000, 16'hFFFF));
        send_pixel(mk_pixel(16'h0001, 16'h0000, 16'h0000));
        send_pixel(mk_pixel(16'h0000, 16'h0001, 16'h0000));
        send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0001));
        send_pixel(mk_pixel(16'h8000, 16'h8000, 16'h8000));
        send_pixel(mk_pixel(16'hFD70, 16'hFD70, 16'hFD70));
        send_pixel(mk_pixel(16'hFFFE, 16'hFFFF, 16'hFFFE));
        send_pixel(mk_pixel(16'h5555, 16'hAAAA, 16'h5555));
        send_pixel(mk_pixel(16'hAAAA, 16'h5555, 16'hAAAA));
        send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'hFFFF));
        release_input();
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel());
        release_input();
    endtask

    // Output side: random stalls by phase, plus a long hold-off when asked.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                pix_sb.check_pixel(out_data);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: count cycles with no beat on either side.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || run_done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        hold_off     = 1'b0;
        run_done     = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        gray_reg     = itm_pkg::MIDDLE_GRAY_RST;
        avg_lum_reg  = itm_pkg::AVG_LOG_LUM_RST;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first.
        set_idle_phase(PH_NONE);
        run_directed();
        run_random(100);
        wait_idle();

        // Extremes of both registers, plus the ignored upper bits.
        reg_write(ADDR_MIDDLE_GRAY, 32'hFFFF_FFFF);
        reg_write(ADDR_AVG_LOG_LUM, 32'h0000_0029);
        set_idle_phase(PH_SRC);
        run_directed();
        run_random(200);
        wait_idle();

        reg_write(ADDR_MIDDLE_GRAY, 32'h0000_028F);
        reg_write(ADDR_AVG_LOG_LUM, 32'h0000_A000);
        set_idle_phase(PH_SNK);
        run_random(250);
        wait_idle();

        reg_write(ADDR_MIDDLE_GRAY, 32'hABCD_0000);
        reg_write(ADDR_AVG_LOG_LUM, 32'hFFFF_FFFF);
        set_idle_phase(PH_BOTH);
        run_directed();
        run_random(200);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering: fill and stall the pipe.
        reg_write(ADDR_MIDDLE_GRAY, 32'($urandom_range(65535, 655)));
        reg_write(ADDR_AVG_LOG_LUM, 32'($urandom_range(40960, 41)));
        set_idle_phase(PH_NONE);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            run_random(200);
        join
        wait_idle();

        // Sender pauses until everything drains, then resumes under mixed stalls.
        for (int p = 0; p < 4; p++)
        begin
            reg_write(ADDR_MIDDLE_GRAY, 32'($urandom_range(65535, 655)));
            reg_write(ADDR_AVG_LOG_LUM, 32'($urandom_range(40960, 41)));
            set_idle_phase(idle_phase_e'(p));
            run_random(100);
            wait_idle();
        end

        run_done = 1'b1;
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/itm_pkg.sv
design/itm_log_cell.sv
design/itm_div_cell.sv
design/inverse_exp_tone_map.sv
design/itm_checker.sv
dv/tb_inverse_exp_tone_map.sv
